// File: rtl/rts_pkg.sv
// Package: shared constants, action codes, status codes and types for the scheduler.
`default_nettype none
package rts_pkg;
  localparam int NUM_TASKS = 8;
  localparam int NUM_ALARMS = 4;
  localparam int NUM_MUTEXES = 4;
  localparam int TICK_WIDTH = 16;
  localparam int TW = 4;
  localparam int AW = 2;
  localparam int MW = 2;
  localparam logic [TW-1:0] IDLE_TASK = TW'(NUM_TASKS);
  localparam logic [3:0] OWNER_FREE = 4'hf;
  localparam logic [2:0] WAIT_NONE = 3'h7;

  typedef enum logic [2:0] {
    ACT_START = 3'd0, ACT_TICK = 3'd1, ACT_SET_EVENT = 3'd2, ACT_WAIT_EVENT = 3'd3,
    ACT_SET_ALARM = 3'd4, ACT_WAIT_ALARM = 3'd5, ACT_MUTEX_GET = 3'd6,
    ACT_MUTEX_REL = 3'd7
  } action_t;

  typedef enum logic [2:0] {
    ST_OK = 3'd0, ST_BLOCKED = 3'd1, ST_BAD_ID = 3'd2, ST_IDLE_WAIT = 3'd3,
    ST_ALARM_OFF = 3'd4, ST_NOT_OWNED = 3'd5
  } status_t;

  localparam logic [2:0] CFG_TASKS_PRESENT = 3'd0;
  localparam logic [2:0] CFG_ALARM_OWNERS = 3'd1;
endpackage
`default_nettype wire

// File: rtl/rts_alarm_unit.sv
// Alarm countdown unit: one shared decrementer stepped over the alarms one per cycle.
`default_nettype none
module rts_alarm_unit import rts_pkg::*; (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  scan_start,
  input  wire logic                  set_en,
  input  wire logic [AW-1:0]         set_idx,
  input  wire logic [TICK_WIDTH-1:0] set_val,
  input  wire logic [15:0]           owners,
  input  wire logic [AW-1:0]         rd_idx,
  output logic                       rd_zero,
  output logic                       busy,
  output logic [NUM_TASKS-1:0]       wake
);
  logic [TICK_WIDTH-1:0] alarm_ticks [NUM_ALARMS];
  logic [AW-1:0] scan_idx;
  logic [TICK_WIDTH-1:0] dec;
  logic [3:0] owner;

  assign rd_zero = (alarm_ticks[rd_idx] == '0);
  assign dec = alarm_ticks[scan_idx] - TICK_WIDTH'(1);
  assign owner = 4'(owners >> {scan_idx, 2'b00});

  // Step one alarm per cycle through the shared decrementer
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      scan_idx <= '0;
      wake <= '0;
      for (int i = 0; i < NUM_ALARMS; i++) alarm_ticks[i] <= '0;
    end else if (scan_start) begin
      busy <= 1'b1;
      scan_idx <= '0;
      wake <= '0;
    end else if (busy) begin
      if (alarm_ticks[scan_idx] != '0) begin
        alarm_ticks[scan_idx] <= dec;
        if (dec == '0 && owner < 4'(NUM_TASKS)) wake[owner[2:0]] <= 1'b1;
      end
      if (scan_idx == AW'(NUM_ALARMS - 1)) busy <= 1'b0;
      scan_idx <= scan_idx + AW'(1);
    end else if (set_en) begin
      alarm_ticks[set_idx] <= set_val;
    end
  end
endmodule
`default_nettype wire

// File: rtl/rtos_task_scheduler_top.sv
// Top level: command decode, task state and reschedule sequencer.
// Sequence: capture, execute and reschedule for most commands; a tick runs execute,
// four alarms scanned through one decrementer, merge wake-ups, reschedule.
// Flow: one request at a time; the next is taken the cycle after the result
// is taken.
// Reset (rst, synchronous): idle task runs, no task ready, flags and alarms clear,
// all mutexes free, configuration registers zero.
`default_nettype none
module rtos_task_scheduler_top import rts_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [2:0]  action,
  input  wire logic [2:0]  target_task,
  input  wire logic [7:0]  event_bits,
  input  wire logic [1:0]  alarm_number,
  input  wire logic [15:0] tick_count,
  input  wire logic [1:0]  mutex_number,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [3:0]       running_task,
  output logic             switched,
  output logic [7:0]       events_granted,
  output logic [2:0]       status,
  input  wire logic        cfg_we,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [15:0] cfg_data
);
  typedef enum logic [3:0] {
    S_IDLE = 4'b0001, S_EXEC = 4'b0010, S_SCAN = 4'b0100, S_SCHED = 4'b1000
  } state_t;
  state_t state;

  logic [7:0]  tasks_present;
  logic [15:0] alarm_owners;
  logic [TW-1:0] current_task;
  logic [NUM_TASKS-1:0] ready_bits;
  logic [7:0] event_flags [NUM_TASKS];
  logic [7:0] event_wait_mask [NUM_TASKS];
  logic [NUM_TASKS-1:0] event_wait_pending;
  logic [3:0] mutex_owner [NUM_MUTEXES];
  logic [2:0] mutex_waited [NUM_TASKS+1];

  action_t act;
  logic [2:0] tgt;
  logic [7:0] ebits;
  logic [1:0] anum;
  logic [15:0] tcnt;
  logic [1:0] mnum;
  logic resched;

  logic scan_start, set_en, a_zero, a_busy;
  logic [NUM_TASKS-1:0] wake;
  logic [3:0] aown;
  logic [2:0] cur3;

  assign in_stall = (state != S_IDLE) || out_valid;
  assign cur3 = current_task[2:0];
  assign aown = 4'(alarm_owners >> {anum, 2'b00});
  assign scan_start = (state == S_EXEC) && (act == ACT_TICK);
  assign set_en = (state == S_EXEC) && (act == ACT_SET_ALARM);

  rts_alarm_unit u_alarm (
    .clk, .rst, .scan_start, .set_en, .set_idx(anum), .set_val(tcnt),
    .owners(alarm_owners), .rd_idx(anum), .rd_zero(a_zero), .busy(a_busy), .wake
  );

  // Pick lowest ready task, then follow an owned mutex
  logic [TW-1:0] pick, pick_final;
  logic [2:0] w;
  logic [3:0] own;
  always_comb begin
    pick = IDLE_TASK;
    for (int t = NUM_TASKS - 1; t >= 0; t--) if (ready_bits[t]) pick = TW'(t);
    w = mutex_waited[pick];
    own = mutex_owner[w[MW-1:0]];
    pick_final = pick;
    if (w != WAIT_NONE && w < 3'(NUM_MUTEXES) && own != OWNER_FREE) begin
      if (own < 4'(NUM_TASKS) && ready_bits[own[2:0]]) pick_final = own;
      else pick_final = IDLE_TASK;
    end
  end

  // Sequence each request: capture, execute, scan alarms (tick only), reschedule
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      out_valid <= 1'b0;
      tasks_present <= '0;
      alarm_owners <= '0;
      current_task <= IDLE_TASK;
      ready_bits <= '0;
      event_wait_pending <= '0;
      resched <= 1'b0;
      for (int i = 0; i < NUM_TASKS; i++) begin
        event_flags[i] <= '0;
        event_wait_mask[i] <= '0;
      end
      for (int i = 0; i < NUM_MUTEXES; i++) mutex_owner[i] <= OWNER_FREE;
      for (int i = 0; i <= NUM_TASKS; i++) mutex_waited[i] <= WAIT_NONE;
    end else begin
      if (cfg_we) begin
        if (cfg_index == CFG_TASKS_PRESENT) tasks_present <= cfg_data[7:0];
        else if (cfg_index == CFG_ALARM_OWNERS) alarm_owners <= cfg_data;
      end
      if (out_valid && !out_stall) out_valid <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (in_valid && !in_stall) begin
            act <= action_t'(action);
            tgt <= target_task;
            ebits <= event_bits;
            anum <= alarm_number;
            tcnt <= tick_count;
            mnum <= mutex_number;
            state <= S_EXEC;
          end
        end
        S_EXEC: begin
          resched <= 1'b0;
          events_granted <= '0;
          status <= ST_OK;
          state <= S_SCHED;
          unique case (act)
            ACT_START: begin
              ready_bits <= tasks_present[NUM_TASKS-1:0];
              for (int i = 0; i < NUM_MUTEXES; i++) mutex_owner[i] <= OWNER_FREE;
              for (int i = 0; i <= NUM_TASKS; i++) mutex_waited[i] <= WAIT_NONE;
              resched <= 1'b1;
            end
            ACT_TICK: begin
              resched <= 1'b1;
              state <= S_SCAN;
            end
            ACT_SET_EVENT: begin
              event_flags[tgt] <= event_flags[tgt] | ebits;
              if ((ebits & event_wait_mask[tgt]) != '0) begin
                ready_bits[tgt] <= 1'b1;
                resched <= 1'b1;
              end
            end
            ACT_WAIT_EVENT: begin
              if (current_task == IDLE_TASK) status <= ST_IDLE_WAIT;
              else if (event_wait_pending[cur3] || (ebits & event_flags[cur3]) != '0) begin
                events_granted <= event_flags[cur3] & ebits;
                event_flags[cur3] <= event_flags[cur3] & ~ebits;
                event_wait_mask[cur3] <= '0;
                event_wait_pending[cur3] <= 1'b0;
              end else begin
                event_wait_mask[cur3] <= ebits;
                event_wait_pending[cur3] <= 1'b1;
                ready_bits[cur3] <= 1'b0;
                resched <= 1'b1;
                status <= ST_BLOCKED;
              end
            end
            ACT_SET_ALARM: ;
            ACT_WAIT_ALARM: begin
              if (current_task == IDLE_TASK) status <= ST_IDLE_WAIT;
              else if (aown != current_task) status <= ST_NOT_OWNED;
              else if (a_zero) status <= ST_ALARM_OFF;
              else begin
                ready_bits[cur3] <= 1'b0;
                resched <= 1'b1;
                status <= ST_BLOCKED;
              end
            end
            ACT_MUTEX_GET: begin
              if (mutex_owner[mnum] == OWNER_FREE) begin
                mutex_waited[current_task] <= WAIT_NONE;
                mutex_owner[mnum] <= current_task;
              end else begin
                mutex_waited[current_task] <= 3'(mnum);
                resched <= 1'b1;
                status <= ST_BLOCKED;
              end
            end
            ACT_MUTEX_REL: begin
              mutex_owner[mnum] <= OWNER_FREE;
              resched <= 1'b1;
            end
            default: ;
          endcase
        end
        S_SCAN: begin
          if (!a_busy) begin
            ready_bits <= ready_bits | wake;
            state <= S_SCHED;
          end
        end
        S_SCHED: begin
          if (resched) current_task <= pick_final;
          running_task <= resched ? pick_final : current_task;
          switched <= resched;
          out_valid <= 1'b1;
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule
`default_nettype wire

// File: rtl/rts_checker.sv
// Port checker for the scheduler, bound to the top level.
`default_nettype none
module rts_checker import rts_pkg::*; (
  input wire logic       clk,
  input wire logic       rst,
  input wire logic       in_valid,
  input wire logic       in_stall,
  input wire logic       out_valid,
  input wire logic       out_stall,
  input wire logic [3:0] running_task,
  input wire logic       switched,
  input wire logic [7:0] events_granted,
  input wire logic [2:0] status
);
  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(running_task))
    else $error("result dropped under stall");
  a_task_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> running_task <= IDLE_TASK) else $error("task out of range");
  a_status_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> status <= ST_NOT_OWNED) else $error("bad status code");
  a_blocked_switch: assert property (@(posedge clk) disable iff (rst)
    out_valid && status == ST_BLOCKED |-> switched && events_granted == 8'd0)
    else $error("blocked without reschedule");
  a_busy_stall: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall) else $error("second request taken");
endmodule

bind rtos_task_scheduler_top rts_checker u_chk (.*);
`default_nettype wire

// File: bench/tb_rtos_task_scheduler_top.sv
// Testbench for the scheduler top: runs command sequences against a built-in predictor.
`timescale 1ns / 1ps
module tb_rtos_task_scheduler_top;
  import rts_pkg::*;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [2:0] action = '0;
  logic [2:0] target_task = '0;
  logic [7:0] event_bits = '0;
  logic [1:0] alarm_number = '0;
  logic [15:0] tick_count = '0;
  logic [1:0] mutex_number = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [3:0] running_task;
  logic switched;
  logic [7:0] events_granted;
  logic [2:0] status;
  logic cfg_we = 1'b0;
  logic [2:0] cfg_index = '0;
  logic [15:0] cfg_data = '0;

  typedef struct packed {
    logic [3:0] running_task;
    logic       switched;
    logic [7:0] events_granted;
    logic [2:0] status;
  } sched_result_t;

  sched_result_t expected_results[$];
  int errors = 0;
  int send_idle_pct = 0;
  int stall_pct = 0;
  int hold_off_cycles = 0;

  // Predictor state
  logic [7:0] m_tasks_present;
  logic [15:0] m_alarm_owners;
  logic [3:0] m_current;
  logic [7:0] m_ready;
  logic [7:0] m_flags [NUM_TASKS];
  logic [7:0] m_wait_mask [NUM_TASKS];
  logic m_wait_pending [NUM_TASKS];
  logic [15:0] m_alarm_ticks [NUM_ALARMS];
  logic [3:0] m_mutex_owner [NUM_MUTEXES];
  logic [2:0] m_mutex_waited [NUM_TASKS + 1];

  rtos_task_scheduler_top uut (.*);

  always #1 clk = ~clk;

  // Clear the predictor to its reset image
  task automatic reset_predictor();
    m_tasks_present = '0;
    m_alarm_owners = '0;
    m_current = IDLE_TASK;
    m_ready = '0;
    for (int i = 0; i < NUM_TASKS; i++) begin
      m_flags[i] = '0;
      m_wait_mask[i] = '0;
      m_wait_pending[i] = 1'b0;
    end
    for (int i = 0; i < NUM_ALARMS; i++) m_alarm_ticks[i] = '0;
    for (int i = 0; i < NUM_MUTEXES; i++) m_mutex_owner[i] = OWNER_FREE;
    for (int i = 0; i <= NUM_TASKS; i++) m_mutex_waited[i] = WAIT_NONE;
  endtask

  function automatic bit is_ready(logic [3:0] t);
    return (t < NUM_TASKS) && m_ready[t[2:0]];
  endfunction

  // Pick the lowest ready task, then apply mutex inheritance
  task automatic pick_next_task();
    logic [3:0] nxt;
    logic [2:0] w;
    nxt = IDLE_TASK;
    for (int t = NUM_TASKS - 1; t >= 0; t--) if (m_ready[t]) nxt = 4'(t);
    w = m_mutex_waited[nxt];
    if (w != WAIT_NONE && w < NUM_MUTEXES && m_mutex_owner[w[1:0]] != OWNER_FREE) begin
      nxt = m_mutex_owner[w[1:0]];
      if (!is_ready(nxt)) nxt = IDLE_TASK;
    end
    m_current = nxt;
  endtask

  // Compute the result of one scheduler command and advance the predictor
  task automatic predict_command(logic [2:0] act, logic [2:0] tgt, logic [7:0] bits,
                                 logic [1:0] alm, logic [15:0] ticks, logic [1:0] mtx);
    sched_result_t r;
    logic [3:0] cur;
    logic [3:0] own;
    cur = m_current;
    r = '0;
    case (action_t'(act))
      ACT_START: begin
        m_ready = m_tasks_present;
        for (int i = 0; i <= NUM_TASKS; i++) m_mutex_waited[i] = WAIT_NONE;
        for (int i = 0; i < NUM_MUTEXES; i++) m_mutex_owner[i] = OWNER_FREE;
        m_current = IDLE_TASK;
        pick_next_task();
        r.switched = 1'b1;
      end
      ACT_TICK: begin
        for (int i = 0; i < NUM_ALARMS; i++) begin
          if (m_alarm_ticks[i] != 0) begin
            m_alarm_ticks[i] = m_alarm_ticks[i] - 16'd1;
            own = m_alarm_owners[i*4 +: 4];
            if (m_alarm_ticks[i] == 0 && own < NUM_TASKS) m_ready[own[2:0]] = 1'b1;
          end
        end
        pick_next_task();
        r.switched = 1'b1;
      end
      ACT_SET_EVENT: begin
        m_flags[tgt] |= bits;
        if ((bits & m_wait_mask[tgt]) != 0) begin
          m_ready[tgt] = 1'b1;
          pick_next_task();
          r.switched = 1'b1;
        end
      end
      ACT_WAIT_EVENT: begin
        if (cur >= NUM_TASKS) r.status = ST_IDLE_WAIT;
        else if (m_wait_pending[cur[2:0]] || (bits & m_flags[cur[2:0]]) != 0) begin
          r.events_granted = m_flags[cur[2:0]] & bits;
          m_flags[cur[2:0]] &= ~bits;
          m_wait_mask[cur[2:0]] = '0;
          m_wait_pending[cur[2:0]] = 1'b0;
        end else begin
          m_wait_mask[cur[2:0]] = bits;
          m_wait_pending[cur[2:0]] = 1'b1;
          m_ready[cur[2:0]] = 1'b0;
          pick_next_task();
          r.switched = 1'b1;
          r.status = ST_BLOCKED;
        end
      end
      ACT_SET_ALARM: m_alarm_ticks[alm] = ticks;
      ACT_WAIT_ALARM: begin
        if (cur >= NUM_TASKS) r.status = ST_IDLE_WAIT;
        else if (m_alarm_owners[alm*4 +: 4] != cur) r.status = ST_NOT_OWNED;
        else if (m_alarm_ticks[alm] == 0) r.status = ST_ALARM_OFF;
        else begin
          m_ready[cur[2:0]] = 1'b0;
          pick_next_task();
          r.switched = 1'b1;
          r.status = ST_BLOCKED;
        end
      end
      ACT_MUTEX_GET: begin
        if (m_mutex_owner[mtx] == OWNER_FREE) begin
          m_mutex_waited[cur] = WAIT_NONE;
          m_mutex_owner[mtx] = cur;
        end else begin
          m_mutex_waited[cur] = {1'b0, mtx};
          pick_next_task();
          r.switched = 1'b1;
          r.status = ST_BLOCKED;
        end
      end
      default: begin
        m_mutex_owner[mtx] = OWNER_FREE;
        pick_next_task();
        r.switched = 1'b1;
      end
    endcase
    r.running_task = m_current;
    expected_results.push_back(r);
  endtask

  // Offer one request, predict it on acceptance; valid stays up for a following request
  task automatic send_command(logic [2:0] act, logic [2:0] tgt, logic [7:0] bits,
                              logic [1:0] alm, logic [15:0] ticks, logic [1:0] mtx);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    action <= act;
    target_task <= tgt;
    event_bits <= bits;
    alarm_number <= alm;
    tick_count <= ticks;
    mutex_number <= mtx;
    in_valid <= 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predict_command(act, tgt, bits, alm, ticks, mtx);
    @(negedge clk);
  endtask

  task automatic send_random(int task_bias);
    logic [2:0] act;
    act = 3'($urandom_range(7));
    // Favor event and alarm traffic that reaches blocked and resumed states
    if ($urandom_range(99) < task_bias) act = $urandom_range(1) ? ACT_TICK : ACT_SET_EVENT;
    send_command(act, 3'($urandom), 8'($urandom),
                 2'($urandom), $urandom_range(3) == 0 ? 16'($urandom) : 16'($urandom_range(4)),
                 2'($urandom));
  endtask

  task automatic write_reg(logic [2:0] idx, logic [15:0] val);
    cfg_index <= idx;
    cfg_data <= val;
    cfg_we <= 1'b1;
    @(negedge clk);
    cfg_we <= 1'b0;
    if (idx == CFG_TASKS_PRESENT) m_tasks_present = val[7:0];
    else if (idx == CFG_ALARM_OWNERS) m_alarm_owners = val;
    @(negedge clk);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (expected_results.size() != 0) @(negedge clk);
    repeat (10) @(negedge clk);
  endtask

  // Directed: field extremes, every action and corner cases
  task automatic test_directed();
    send_command(ACT_WAIT_EVENT, 3'd0, 8'hff, 2'd0, 16'd0, 2'd0);
    send_command(ACT_WAIT_ALARM, 3'd0, 8'h00, 2'd3, 16'd0, 2'd0);
    send_command(ACT_MUTEX_GET, 3'd0, 8'h00, 2'd0, 16'd0, 2'd3);
    send_command(ACT_MUTEX_GET, 3'd0, 8'h00, 2'd0, 16'd0, 2'd3);
    wait_drained();
    write_reg(CFG_TASKS_PRESENT, 16'h00ff);
    write_reg(CFG_ALARM_OWNERS, 16'hf210);
    send_command(ACT_START, 3'd7, 8'h00, 2'd0, 16'd0, 2'd0);
    send_command(ACT_SET_ALARM, 3'd0, 8'h00, 2'd0, 16'hffff, 2'd0);
    send_command(ACT_SET_ALARM, 3'd0, 8'h00, 2'd3, 16'd1, 2'd0);
    send_command(ACT_WAIT_ALARM, 3'd0, 8'h00, 2'd3, 16'd0, 2'd0);
    send_command(ACT_WAIT_ALARM, 3'd0, 8'h00, 2'd1, 16'd0, 2'd0);
    send_command(ACT_WAIT_ALARM, 3'd0, 8'h00, 2'd0, 16'd0, 2'd0);
    send_command(ACT_TICK, 3'd0, 8'h00, 2'd0, 16'd0, 2'd0);
    send_command(ACT_MUTEX_GET, 3'd0, 8'h00, 2'd0, 16'd0, 2'd2);
    send_command(ACT_WAIT_EVENT, 3'd0, 8'h81, 2'd0, 16'd0, 2'd0);
    send_command(ACT_MUTEX_GET, 3'd0, 8'h00, 2'd0, 16'd0, 2'd2);
    send_command(ACT_SET_EVENT, 3'd5, 8'h40, 2'd0, 16'd0, 2'd0);
    send_command(ACT_SET_EVENT, 3'd1, 8'h01, 2'd0, 16'd0, 2'd0);
    send_command(ACT_MUTEX_REL, 3'd0, 8'h00, 2'd0, 16'd0, 2'd1);
    send_command(ACT_MUTEX_REL, 3'd0, 8'h00, 2'd0, 16'd0, 2'd2);
    send_command(ACT_WAIT_EVENT, 3'd0, 8'h00, 2'd0, 16'd0, 2'd0);
    send_command(ACT_SET_EVENT, 3'd0, 8'h80, 2'd0, 16'd0, 2'd0);
    send_command(ACT_WAIT_EVENT, 3'd0, 8'h00, 2'd0, 16'd0, 2'd0);
    send_command(ACT_WAIT_EVENT, 3'd0, 8'hff, 2'd0, 16'd0, 2'd0);
    wait_drained();
  endtask

  // Random: one phase per idling pattern and register setting
  task automatic test_random_phase(int s_idle, int r_stall, logic [7:0] present,
                                   logic [15:0] owners, int count);
    send_idle_pct = s_idle;
    stall_pct = r_stall;
    write_reg(CFG_TASKS_PRESENT, {8'h00, present});
    write_reg(CFG_ALARM_OWNERS, owners);
    send_command(ACT_START, 3'($urandom), 8'($urandom), 2'($urandom), 16'($urandom), 2'($urandom));
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(49) == 0)
        send_command(ACT_START, 3'($urandom), 8'($urandom), 2'($urandom), 16'($urandom), 2'd0);
      else send_random(30);
    end
    wait_drained();
  endtask

  // Hold the receiver off while requests keep arriving
  task automatic test_backpressure();
    send_idle_pct = 0;
    stall_pct = 0;
    hold_off_cycles = 200;
    for (int i = 0; i < 20; i++) send_random(30);
    wait_drained();
  endtask

  // Receiver stall driver
  always @(negedge clk) begin
    if (hold_off_cycles > 0) begin
      out_stall <= 1'b1;
      hold_off_cycles <= hold_off_cycles - 1;
    end else begin
      out_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  // Compare each result with the oldest expectation
  always @(posedge clk) begin
    sched_result_t exp_r;
    if (!rst && out_valid && !out_stall) begin
      if (expected_results.size() == 0) begin
        $error("unexpected result running_task=%0d", running_task);
        errors++;
      end else begin
        exp_r = expected_results.pop_front();
        if (running_task !== exp_r.running_task) begin
          $error("running_task expected %0d actual %0d", exp_r.running_task, running_task);
          errors++;
        end
        if (switched !== exp_r.switched) begin
          $error("switched expected %0d actual %0d", exp_r.switched, switched);
          errors++;
        end
        if (events_granted !== exp_r.events_granted) begin
          $error("events_granted expected %0h actual %0h", exp_r.events_granted,
                 events_granted);
          errors++;
        end
        if (status !== exp_r.status) begin
          $error("status expected %0d actual %0d", exp_r.status, status);
          errors++;
        end
      end
    end
  end

  initial begin
    reset_predictor();
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    test_directed();
    test_random_phase(0, 0, 8'hff, 16'h3210, 250);
    test_random_phase(88, 0, 8'h0f, 16'h7531, 250);
    test_random_phase(0, 88, 8'h00, 16'hffff, 200);
    test_random_phase(6, 6, 8'haa, 16'h8765, 250);
    test_random_phase(0, 0, 8'h81, 16'h0000, 200);
    test_backpressure();
    test_random_phase(30, 30, 8'($urandom), 16'($urandom), 250);
    if (expected_results.size() != 0) begin
      $error("%0d results never arrived", expected_results.size());
      errors++;
    end
    if (errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #2000000;
    $display("Simulation FAILED");
    $finish;
  end
endmodule
